FILE: rtl/core/wtpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wtpg_pkg;

  localparam int unsigned MaxTableSize  = 65536;
  localparam int unsigned LevelFracBits = 24;
  localparam int unsigned LevelW        = LevelFracBits + 1;
  localparam int unsigned IndexW        = 16;
  localparam int unsigned SizeW         = 17;
  localparam int unsigned PhaseW        = 16;
  localparam int unsigned SampleW       = 32;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned AngleW        = 32;
  localparam int unsigned CordicSteps   = 30;
  localparam int unsigned CordicW       = 33;

  localparam logic signed [CordicW-1:0] CordicX0 = 33'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [29:0] AtanTurns [CordicSteps] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_FLAT     = 2'd2
  } wave_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAVE_KIND     = 3'd0,
    REG_TABLE_SIZE    = 3'd1,
    REG_PHASE_TURNS   = 3'd2,
    REG_MIN_LEVEL     = 3'd3,
    REG_MAX_LEVEL     = 3'd4,
    REG_NARROW_OUTPUT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        wave_kind;
    logic [SizeW-1:0]  size;
    logic [PhaseW-1:0] phase;
  } front_cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] min_level;
    logic signed [SampleW-1:0] max_level;
    logic                      narrow;
  } back_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/wtpg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wtpg_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wtpg_pkg::front_cfg_t           cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wtpg_pkg::IndexW-1:0]    in_index_i,
  output logic                           push_o,
  output logic [wtpg_pkg::LevelW-1:0]    level_o,
  input  logic                           full_i
);
  import wtpg_pkg::*;

  localparam int unsigned RemSt  = SizeW;
  localparam int unsigned DivSt  = AngleW;
  localparam int unsigned NumSt  = 1 + RemSt + DivSt + 2 + CordicSteps;
  localparam int unsigned ShiftS = 31 - LevelFracBits;
  localparam int unsigned TriW   = LevelFracBits + 4;
  localparam int unsigned OfsW   = SizeW + PhaseW + 1;

  localparam logic signed [TriW-1:0] LvlOne    = TriW'(1) <<< LevelFracBits;
  localparam logic signed [TriW-1:0] LvlHalf   = LvlOne >>> 1;
  localparam logic signed [TriW-1:0] LvlThreeH = LvlOne + LvlHalf;

  localparam logic signed [CordicW:0] YLimit = (CordicW + 1)'(1) <<< 30;
  localparam logic signed [CordicW:0] YRound = (CordicW + 1)'(1) <<< (30 - LevelFracBits);

  localparam logic signed [AngleW+1:0] QuarterTurn = (AngleW + 2)'(1) <<< 30;
  localparam logic signed [AngleW+1:0] HalfTurn    = (AngleW + 2)'(1) <<< 31;

  logic             fe_en;
  logic [NumSt-1:0] vld_q;
  logic [SizeW-1:0] n;

  assign n          = cfg_i.size;
  assign fe_en      = !vld_q[NumSt-1] || !full_i;
  assign in_ready_o = fe_en;
  assign push_o     = vld_q[NumSt-1] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (fe_en) begin
      vld_q <= {vld_q[NumSt-2:0], in_valid_i};
    end
  end

  // Phase offset, rounded half up, added to the index.
  logic [OfsW-1:0]  ofs_prod;
  logic [SizeW-1:0] sum_d, sum_q;

  assign ofs_prod = OfsW'(cfg_i.phase) * OfsW'(n) + OfsW'(32768);
  assign sum_d    = SizeW'(in_index_i) + ofs_prod[SizeW+15:16];

  // Restoring remainder, one bit of the sum per stage.
  logic [SizeW-1:0] rem_d  [RemSt];
  logic [SizeW-1:0] rem_q  [RemSt];
  logic [SizeW-1:0] rsum_d [RemSt];
  logic [SizeW-1:0] rsum_q [RemSt];

  for (genvar k = 0; k < RemSt; k++) begin : g_rem
    logic [SizeW-1:0] rin;
    logic [SizeW-1:0] sin;
    logic [SizeW:0]   trial;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign sin = sum_q;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign sin = rsum_q[k-1];
    end
    assign trial     = {rin, sin[SizeW-1]};
    assign rem_d[k]  = (trial >= {1'b0, n}) ? SizeW'(trial - {1'b0, n}) : SizeW'(trial);
    assign rsum_d[k] = {sin[SizeW-2:0], 1'b0};
  end

  // p * 2^32 / n, one quotient bit per stage.
  logic [SizeW-1:0]  drem_d [DivSt];
  logic [SizeW-1:0]  drem_q [DivSt];
  logic [AngleW-1:0] quo_d  [DivSt];
  logic [AngleW-1:0] quo_q  [DivSt];

  for (genvar k = 0; k < DivSt; k++) begin : g_div
    logic [SizeW-1:0]  rin;
    logic [AngleW-1:0] qin;
    logic [SizeW:0]    trial;
    logic              ge;
    if (k == 0) begin : g_first
      assign rin = rem_q[RemSt-1];
      assign qin = '0;
    end else begin : g_next
      assign rin = drem_q[k-1];
      assign qin = quo_q[k-1];
    end
    assign trial     = {rin, 1'b0};
    assign ge        = trial >= {1'b0, n};
    assign drem_d[k] = ge ? SizeW'(trial - {1'b0, n}) : SizeW'(trial);
    assign quo_d[k]  = {qin[AngleW-2:0], ge};
  end

  // Rounded angle and the triangle level, both from the same quotient.
  logic [AngleW-1:0] quo_l;
  logic [SizeW-1:0]  rem_l;
  logic [AngleW-1:0] ang_d, ang_q;
  logic [AngleW:0]   tri_sum;
  logic signed [TriW-1:0] tri_x, tri_lev;
  logic [LevelW-1:0] tri1_d, tri1_q, tri2_q;

  assign quo_l   = quo_q[DivSt-1];
  assign rem_l   = drem_q[DivSt-1];
  assign ang_d   = quo_l + AngleW'(rem_l >= (n - (n >> 1)));
  assign tri_sum = {1'b0, quo_l} + ((AngleW + 1)'(1) << (ShiftS - 1));
  assign tri_x   = TriW'(tri_sum >> ShiftS);

  always_comb begin
    if (quo_l[AngleW-1:AngleW-2] == '0) begin
      tri_lev = tri_x + LvlHalf;
    end else if (quo_l[AngleW-1:AngleW-2] == '1) begin
      tri_lev = tri_x - LvlThreeH;
    end else begin
      tri_lev = LvlThreeH - tri_x;
    end
    if (tri_lev < 0) begin
      tri1_d = '0;
    end else if (tri_lev > LvlOne) begin
      tri1_d = LevelW'(LvlOne);
    end else begin
      tri1_d = LevelW'(tri_lev);
    end
  end

  // Fold the angle to within a quarter turn of zero.
  logic signed [AngleW+1:0]  ang_w, ang_f;
  logic signed [CordicW-1:0] z0_q;

  assign ang_w = {{2{ang_q[AngleW-1]}}, ang_q};

  always_comb begin
    if (ang_w > QuarterTurn) begin
      ang_f = HalfTurn - ang_w;
    end else if (ang_w < -QuarterTurn) begin
      ang_f = -HalfTurn - ang_w;
    end else begin
      ang_f = ang_w;
    end
  end

  // CORDIC rotation, one micro-rotation per stage.
  logic signed [CordicW-1:0] cx_d [CordicSteps];
  logic signed [CordicW-1:0] cx_q [CordicSteps];
  logic signed [CordicW-1:0] cy_d [CordicSteps];
  logic signed [CordicW-1:0] cy_q [CordicSteps];
  logic signed [CordicW-1:0] cz_d [CordicSteps];
  logic signed [CordicW-1:0] cz_q [CordicSteps];
  logic [LevelW-1:0]         ct_q [CordicSteps];
  logic [LevelW-1:0]         ct_d [CordicSteps];

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    logic signed [CordicW-1:0] xin, yin, zin, dx, dy, at;
    if (k == 0) begin : g_first
      assign xin     = CordicX0;
      assign yin     = '0;
      assign zin     = z0_q;
      assign ct_d[k] = tri2_q;
    end else begin : g_next
      assign xin     = cx_q[k-1];
      assign yin     = cy_q[k-1];
      assign zin     = cz_q[k-1];
      assign ct_d[k] = ct_q[k-1];
    end
    assign dx      = yin >>> k;
    assign dy      = xin >>> k;
    assign at      = CordicW'(AtanTurns[k]);
    assign cx_d[k] = zin[CordicW-1] ? xin + dx : xin - dx;
    assign cy_d[k] = zin[CordicW-1] ? yin - dy : yin + dy;
    assign cz_d[k] = zin[CordicW-1] ? zin + at : zin - at;
  end

  always_ff @(posedge clk_i) begin
    if (fe_en) begin
      sum_q  <= sum_d;
      rem_q  <= rem_d;
      rsum_q <= rsum_d;
      drem_q <= drem_d;
      quo_q  <= quo_d;
      ang_q  <= ang_d;
      tri1_q <= tri1_d;
      z0_q   <= CordicW'(ang_f);
      tri2_q <= tri1_q;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      cz_q   <= cz_d;
      ct_q   <= ct_d;
    end
  end

  // Sine level: clamp y to one, shift to [0, 1] and round.
  logic signed [CordicW:0] y_w, y_c, y_s;
  logic [LevelW-1:0]       sin_lvl;

  assign y_w = (CordicW + 1)'(cy_q[CordicSteps-1]);

  always_comb begin
    if (y_w > YLimit) begin
      y_c = YLimit;
    end else if (y_w < -YLimit) begin
      y_c = -YLimit;
    end else begin
      y_c = y_w;
    end
  end

  assign y_s     = y_c + YLimit + YRound;
  assign sin_lvl = LevelW'(y_s >>> ShiftS);

  always_comb begin
    if (cfg_i.wave_kind == WAVE_SINE) begin
      level_o = sin_lvl;
    end else if (cfg_i.wave_kind == WAVE_TRIANGLE) begin
      level_o = ct_q[CordicSteps-1];
    end else begin
      level_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wtpg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module wtpg_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]  cnt_d, cnt_q;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/wtpg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wtpg_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wtpg_pkg::back_cfg_t         cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wtpg_pkg::LevelW-1:0] level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wtpg_pkg::SampleW-1:0] sample_o,
  output logic                        clip_o
);
  import wtpg_pkg::*;

  localparam int unsigned DiffW = SampleW + 1;
  localparam int unsigned ProdW = LevelW + 1 + DiffW;
  localparam int unsigned MagW  = ProdW - LevelFracBits;
  localparam int unsigned RW    = MagW + 1;

  localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (LevelFracBits - 1);

  localparam logic signed [RW-1:0] WideHi   = RW'(32'sh7fff_ffff);
  localparam logic signed [RW-1:0] WideLo   = RW'(32'sh8000_0000);
  localparam logic signed [RW-1:0] NarrowHi = RW'(16'sh7fff);
  localparam logic signed [RW-1:0] NarrowLo = RW'(16'sh8000);

  logic       be_en;
  logic [3:0] vld_q;

  assign be_en       = !vld_q[3] || out_ready_i;
  assign in_ready_o  = be_en;
  assign out_valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (be_en) begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  // Level times span, then the minimum moved up to the level's scale.
  logic signed [LevelW:0]   lvl_s;
  logic signed [DiffW-1:0]  diff;
  logic signed [ProdW-1:0]  prod_d, prod_q, v_d, v_q;

  assign lvl_s  = {1'b0, level_i};
  assign diff   = DiffW'(cfg_i.max_level) - DiffW'(cfg_i.min_level);
  assign prod_d = lvl_s * diff;
  assign v_d    = prod_q + (ProdW'(cfg_i.min_level) <<< LevelFracBits);

  // Round half away from zero on the magnitude.
  logic [ProdW-1:0] mag, mag_r;
  logic [MagW-1:0]  rm_d, rm_q;
  logic             neg_q;

  assign mag   = v_q[ProdW-1] ? ProdW'(-v_q) : ProdW'(v_q);
  assign mag_r = mag + RoundHalf;
  assign rm_d  = mag_r[ProdW-1:LevelFracBits];

  logic signed [RW-1:0]      r_s, lim_hi, lim_lo;
  logic [SampleW-1:0]        sample_d, sample_q;
  logic                      clip_d, clip_q;

  assign r_s    = neg_q ? -$signed({1'b0, rm_q}) : $signed({1'b0, rm_q});
  assign lim_hi = cfg_i.narrow ? NarrowHi : WideHi;
  assign lim_lo = cfg_i.narrow ? NarrowLo : WideLo;

  always_comb begin
    if (r_s > lim_hi) begin
      sample_d = SampleW'(lim_hi);
      clip_d   = 1'b1;
    end else if (r_s < lim_lo) begin
      sample_d = SampleW'(lim_lo);
      clip_d   = 1'b1;
    end else begin
      sample_d = SampleW'(r_s);
      clip_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_en) begin
      prod_q   <= prod_d;
      v_q      <= v_d;
      rm_q     <= rm_d;
      neg_q    <= v_q[ProdW-1];
      sample_q <= sample_d;
      clip_q   <= clip_d;
    end
  end

  assign sample_o = sample_q;
  assign clip_o   = clip_q;

endmodule

`default_nettype wire

FILE: rtl/core/wave_table_point_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Wave table point generator: takes one table position per item and returns one scaled
// sine, triangle or flat sample per item, one item per clock when the output is taken
// every cycle. It has one stage for the phase offset, 17 remainder stages, 32 angle
// division stages (one bit each), two stages for angle rounding and folding, 30 CORDIC
// stages, the QUEUE_DEPTH entry result queue and four scaling stages ending in the output
// register. The user must write registers only while no item is in flight (not enforced).
module wave_table_point_generator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wtpg_pkg::IndexW-1:0]   s_axis_tdata,   // [15:0] point_index
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [wtpg_pkg::SampleW-1:0]  m_axis_tdata,   // [31:0] sample_value
  output logic                          m_axis_tuser,   // [0] clipped
  input  logic                          cfg_we_i,
  input  logic [wtpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wtpg_pkg::SampleW-1:0]  cfg_data_i
);
  import wtpg_pkg::*;

  logic [1:0]                wave_kind_q;
  logic [SizeW-1:0]          size_q;
  logic [PhaseW-1:0]         phase_q;
  logic signed [SampleW-1:0] min_q, max_q;
  logic                      narrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_kind_q <= WAVE_SINE;
      size_q      <= SizeW'(1024);
      phase_q     <= '0;
      min_q       <= '0;
      max_q       <= SampleW'(32767);
      narrow_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_KIND:     wave_kind_q <= cfg_data_i[1:0];
        REG_TABLE_SIZE:    size_q      <= cfg_data_i[SizeW-1:0];
        REG_PHASE_TURNS:   phase_q     <= cfg_data_i[PhaseW-1:0];
        REG_MIN_LEVEL:     min_q       <= cfg_data_i;
        REG_MAX_LEVEL:     max_q       <= cfg_data_i;
        REG_NARROW_OUTPUT: narrow_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  front_cfg_t fcfg;
  back_cfg_t  bcfg;

  always_comb begin
    fcfg.wave_kind = wave_kind_q;
    fcfg.phase     = phase_q;
    if (size_q == '0) begin
      fcfg.size = SizeW'(1);
    end else if (size_q > SizeW'(MaxTableSize)) begin
      fcfg.size = SizeW'(MaxTableSize);
    end else begin
      fcfg.size = size_q;
    end
    bcfg.min_level = min_q;
    bcfg.max_level = max_q;
    bcfg.narrow    = narrow_q;
  end

  logic              push, full, pop, empty, back_ready;
  logic [LevelW-1:0] front_level, queue_level;

  wtpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (fcfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_index_i (s_axis_tdata),
    .push_o     (push),
    .level_o    (front_level),
    .full_i     (full)
  );

  wtpg_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (LevelW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_level),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_level),
    .empty_o (empty)
  );

  assign pop = !empty && back_ready;

  wtpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (bcfg),
    .in_valid_i  (!empty),
    .in_ready_o  (back_ready),
    .level_i     (queue_level),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (m_axis_tdata),
    .clip_o      (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/core/wtpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wtpg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // An offered input item stays put until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input item changed while stalled");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // A saturated sample sits exactly on one of the range limits.
  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'h0000_7fff
      || m_axis_tdata == 32'hffff_8000 || m_axis_tdata == 32'h7fff_ffff
      || m_axis_tdata == 32'h8000_0000)
    else $error("clipped flag with a value off the limits");

  // No output item is offered after reset is sampled low.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind wave_table_point_generator wtpg_checker u_wtpg_checker (.*);

`default_nettype wire

FILE: bench/wave_table_point_checker.sv
`timescale 1ns / 1ps

module wave_table_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  import wtpg_pkg::*;

  typedef struct packed {
    logic [31:0] sample;
    logic        clipped;
  } sample_t;

  logic [1:0]         kind_q;
  logic [16:0]        size_q;
  logic [15:0]        phase_q;
  logic signed [31:0] min_q;
  logic signed [31:0] max_q;
  logic               narrow_q;

  sample_t expected_samples[$];

  function automatic sample_t compute_sample(logic [15:0] index);
    longint n, off, p, a, z, x, y, dx, dy, lvl, one, tx, q, v, r;
    sample_t res;
    one = longint'(1) << LevelFracBits;
    n = size_q;
    if (n == 0) n = 1;
    if (n > MaxTableSize) n = MaxTableSize;
    off = (longint'(phase_q) * n + 32768) >> 16;
    p = (longint'(index) + off) % n;
    lvl = 0;
    if (kind_q == WAVE_SINE) begin
      a = (((p << 32) + n / 2) / n) & 64'hFFFF_FFFF;
      z = (a >= (longint'(1) << 31)) ? a - (longint'(1) << 32) : a;
      // Fold the angle into the right half plane.
      if (z > (longint'(1) << 30)) z = (longint'(1) << 31) - z;
      else if (z < -(longint'(1) << 30)) z = -(longint'(1) << 31) - z;
      x = longint'(CordicX0);
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(AtanTurns[i]);
        end else begin
          x += dx; y -= dy; z += longint'(AtanTurns[i]);
        end
      end
      if (y > (longint'(1) << 30)) y = longint'(1) << 30;
      if (y < -(longint'(1) << 30)) y = -(longint'(1) << 30);
      lvl = (y + (longint'(1) << 30) + (longint'(1) << (30 - LevelFracBits)))
            >> (31 - LevelFracBits);
    end else if (kind_q == WAVE_TRIANGLE) begin
      tx = (4 * p * one + n) / (2 * n);
      q = 4 * p / n;
      if (q == 0) lvl = tx + one / 2;
      else if (q == 3) lvl = tx - 3 * one / 2;
      else lvl = 3 * one / 2 - tx;
      if (lvl < 0) lvl = 0;
      if (lvl > one) lvl = one;
    end
    v = lvl * (longint'(max_q) - longint'(min_q)) + longint'(min_q) * one;
    if (v >= 0) r = (v + one / 2) >> LevelFracBits;
    else r = -((-v + one / 2) >> LevelFracBits);
    res.clipped = 1'b0;
    if (narrow_q) begin
      if (r > 32767) begin r = 32767; res.clipped = 1'b1; end
      if (r < -32768) begin r = -32768; res.clipped = 1'b1; end
    end
    res.sample = r[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t exp_s;
    if (!rst_ni) begin
      kind_q   <= WAVE_SINE;
      size_q   <= 17'd1024;
      phase_q  <= '0;
      min_q    <= '0;
      max_q    <= 32'sd32767;
      narrow_q <= 1'b0;
      expected_samples.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WAVE_KIND:     kind_q   <= cfg_data_i[1:0];
          REG_TABLE_SIZE:    size_q   <= cfg_data_i[16:0];
          REG_PHASE_TURNS:   phase_q  <= cfg_data_i[15:0];
          REG_MIN_LEVEL:     min_q    <= cfg_data_i;
          REG_MAX_LEVEL:     max_q    <= cfg_data_i;
          REG_NARROW_OUTPUT: narrow_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back(compute_sample(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected item: sample %h clipped %b", $time,
                   m_axis_tdata, m_axis_tuser);
          errors_o <= errors_o + 1;
        end else begin
          exp_s = expected_samples.pop_front();
          if (exp_s.sample !== m_axis_tdata || exp_s.clipped !== m_axis_tuser) begin
            $display("%0t: mismatch: expected sample %h clipped %b, got %h clipped %b",
                     $time, exp_s.sample, exp_s.clipped, m_axis_tdata, m_axis_tuser);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_samples.size();
    end
  end
endmodule

FILE: bench/wave_table_point_generator_tb.sv
`timescale 1ns / 1ps

module wave_table_point_generator_tb;
  import wtpg_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [2:0] RegUnused = 3'd6;
  localparam logic [2:0] RegTop = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;
  longint      cur_size = 1024;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  wave_table_point_generator dut (.*);

  wave_table_point_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("wave_table_point_generator_tb NOT OK");
      $finish;
    end
  end

  // Receiver: short random stalls, or one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [1:0] kind, logic [16:0] size, logic [15:0] phase,
                             logic [31:0] lo, logic [31:0] hi, logic narrow);
    write_reg(REG_WAVE_KIND, 32'(kind));
    write_reg(REG_TABLE_SIZE, 32'(size));
    write_reg(REG_PHASE_TURNS, 32'(phase));
    write_reg(REG_MIN_LEVEL, lo);
    write_reg(REG_MAX_LEVEL, hi);
    write_reg(REG_NARROW_OUTPUT, 32'(narrow));
    cur_size = (size == 0) ? 1 : (size > MaxTableSize ? MaxTableSize : size);
  endtask

  task automatic send_point(logic [15:0] index);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= index;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 80000)) - 32'd40000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [16:0] size;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, including positions beyond the table size.
    send_point(16'd0); send_point(16'd1); send_point(16'd1023);
    send_point(16'd1024); send_point(16'hFFFF); send_point(16'h5555);
    drain();
    load_config(WAVE_TRIANGLE, 17'd4, 16'd0, 32'd0, 32'd1000, 1'b0);
    for (int i = 0; i < 4; i++) send_point(i[15:0]);
    drain();
    load_config(WAVE_SINE, 17'd0, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(16'd0); send_point(16'hAAAA);
    drain();
    load_config(WAVE_TRIANGLE, 17'h1FFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(16'd0); send_point(16'd16384); send_point(16'hFFFF);
    drain();
    load_config(WAVE_FLAT, 17'd65536, 16'h8000, 32'hFFFF_8000, 32'd5, 1'b0);
    send_point(16'd7);
    drain();
    write_reg(REG_WAVE_KIND, 32'd3);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    write_reg(RegTop, 32'h0);
    send_point(16'd9);
    drain();
    load_config(WAVE_SINE, 17'd65535, 16'h4000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_point(16'd0); send_point(16'd16384); send_point(16'd49151); send_point(16'hFFFF);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 3))
        0: size = 17'($urandom_range(1, 8));
        1: size = 17'($urandom_range(9, 4096));
        2: size = 17'd65536;
        default: size = 17'($urandom);
      endcase
      load_config(2'($urandom_range(0, 3)), size, 16'($urandom), pick_level(),
                  pick_level(), 1'($urandom));
      if (ph == 3) long_hold = 1'b1;
      if (ph == 13) calm = 1'b1;
      // The long hold-off phase sends more items than the pipeline holds.
      for (int k = 0; k < ((ph == 3) ? 200 : 80); k++) begin
        if ($urandom_range(0, 7) == 0) send_point(16'($urandom));
        else send_point(16'($urandom_range(0, int'(cur_size) - 1)));
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("wave_table_point_generator_tb OK");
    end else begin
      $display("wave_table_point_generator_tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/wtpg_pkg.sv
rtl/core/wtpg_front.sv
rtl/core/wtpg_fifo.sv
rtl/core/wtpg_back.sv
rtl/core/wave_table_point_generator.sv
rtl/core/wtpg_checker.sv
bench/wave_table_point_checker.sv
bench/wave_table_point_generator_tb.sv
